// ===== rtl/ptev_pkg.sv =====
// Shared types, widths and helpers for the polynomial trajectory evaluator.
// Used by the coefficient store, the multiply-accumulate unit, the sequencer and the top level.
`default_nettype none
package ptev_pkg;

  localparam int COEFF_W    = 32;
  localparam int TVAL_W     = 24;
  localparam int TIME_W     = 23;
  localparam int ACC_W      = 48;
  localparam int ORDER_W    = 3;
  localparam int DIM_W      = 2;
  localparam int WEIGHT_W   = 6;
  localparam int WC_W       = COEFF_W + WEIGHT_W + 1;
  localparam int HALF_W     = 24;
  localparam int PROD_W     = HALF_W + TIME_W;
  localparam int FULL_W     = PROD_W + HALF_W;
  localparam int FRAC_W     = 16;
  localparam int P_W        = FULL_W - FRAC_W;
  localparam int SUM_W      = P_W + 2;
  localparam int NUM_CHAINS = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic [FULL_W-1:0] ROUND_HALF = FULL_W'(1) << (FRAC_W - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS  = 2'd1;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd5;
  localparam logic [DIM_W-1:0]   DIMS_RESET  = 2'd3;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CH_POS = 2'd0,
    CH_VEL = 2'd1,
    CH_ACC = 2'd2
  } chain_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_STEP  = 2'd1,
    ST_DRAIN = 2'd2
  } state_t;

  typedef logic signed [ACC_W-1:0] q48_t;

  typedef struct packed {
    logic                valid;
    logic                load;
    chain_t              chain;
    logic [WEIGHT_W-1:0] weight;
  } issue_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [DIM_W-1:0] dim;
  } emit_t;

  // Derivative weight of coefficient j: 1, j, or j(j-1).
  function automatic logic [WEIGHT_W-1:0] deriv_weight(input logic [ORDER_W-1:0] j,
                                                       input chain_t chain);
    logic [WEIGHT_W-1:0] jw;
    logic [WEIGHT_W-1:0] w;
    jw = WEIGHT_W'(j);
    unique case (chain)
      CH_POS: w = WEIGHT_W'(1);
      CH_VEL: w = jw;
      CH_ACC: w = (j == '0) ? '0 : WEIGHT_W'(jw * (jw - WEIGHT_W'(1)));
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ptev_store.sv =====
// Coefficient store: synchronous memory with a registered read and per-entry valid bits.
// An entry that was never written since reset reads as zero. Depends on ptev_pkg.
`default_nettype none
module ptev_store #(
  parameter int DEPTH = 18,
  parameter int AW    = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [AW-1:0]                      wr_addr,
  input  logic signed [ptev_pkg::COEFF_W-1:0] wr_data,
  input  logic [AW-1:0]                      rd_addr,
  output logic signed [ptev_pkg::COEFF_W-1:0] rd_data
);
  import ptev_pkg::*;

  logic signed [COEFF_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          valid;
  logic signed [COEFF_W-1:0] rd_q;
  logic                      rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid_q <= valid[rd_addr];
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule
`default_nettype wire

// ===== rtl/ptev_mac.sv =====
// Shared Horner multiply-accumulate pipeline with one accumulator per derivative chain.
// Computes acc = sat(round(acc * t) + w * c), acc zero on a load. Depends on ptev_pkg.
`default_nettype none
module ptev_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  ptev_pkg::issue_t                    issue,
  input  logic signed [ptev_pkg::COEFF_W-1:0] coeff,
  input  logic [ptev_pkg::TIME_W-1:0]         t_val,
  output ptev_pkg::q48_t                      acc [ptev_pkg::NUM_CHAINS]
);
  import ptev_pkg::*;

  logic signed [ACC_W-1:0] src;
  logic [ACC_W-1:0]        mag;
  logic signed [WC_W-1:0]  wc;

  logic                    s1_valid;
  chain_t                  s1_chain;
  logic                    s1_neg;
  logic [HALF_W-1:0]       s1_mag_hi;
  logic [PROD_W-1:0]       s1_lo;
  logic signed [WC_W-1:0]  s1_wc;

  logic                    s2_valid;
  chain_t                  s2_chain;
  logic                    s2_neg;
  logic [PROD_W-1:0]       s2_hi;
  logic [PROD_W-1:0]       s2_lo;
  logic signed [WC_W-1:0]  s2_wc;

  logic [FULL_W-1:0]       full_sum;
  logic                    s3_valid;
  chain_t                  s3_chain;
  logic                    s3_neg;
  logic [P_W-1:0]          s3_p;
  logic signed [WC_W-1:0]  s3_wc;

  logic signed [SUM_W-1:0] sp;
  logic signed [SUM_W-1:0] total;
  logic signed [ACC_W-1:0] sat_val;

  always_comb begin
    src = issue.load ? '0 : acc[issue.chain];
    mag = src[ACC_W-1] ? ACC_W'(-src) : ACC_W'(src);
    wc  = WC_W'(coeff) * $signed(WC_W'({1'b0, issue.weight}));
  end

  always_ff @(posedge clk) begin
    s1_chain  <= issue.chain;
    s1_neg    <= src[ACC_W-1];
    s1_mag_hi <= mag[ACC_W-1:HALF_W];
    s1_lo     <= PROD_W'(mag[HALF_W-1:0]) * PROD_W'(t_val);
    s1_wc     <= wc;

    s2_chain  <= s1_chain;
    s2_neg    <= s1_neg;
    s2_hi     <= PROD_W'(s1_mag_hi) * PROD_W'(t_val);
    s2_lo     <= s1_lo;
    s2_wc     <= s1_wc;

    s3_chain  <= s2_chain;
    s3_neg    <= s2_neg;
    s3_p      <= full_sum[FULL_W-1:FRAC_W];
    s3_wc     <= s2_wc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= issue.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  assign full_sum = {s2_hi, HALF_W'(0)} + FULL_W'(s2_lo) + ROUND_HALF;

  always_comb begin
    sp    = s3_neg ? -$signed({2'b00, s3_p}) : $signed({2'b00, s3_p});
    total = sp + {{(SUM_W-WC_W){s3_wc[WC_W-1]}}, s3_wc};
    if (total[SUM_W-1:ACC_W-1] == '0 || total[SUM_W-1:ACC_W-1] == '1) begin
      sat_val = total[ACC_W-1:0];
    end else if (total[SUM_W-1]) begin
      sat_val = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      acc[s3_chain] <= sat_val;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ptev_ctrl.sv =====
// Sequencer for evaluation: walks dimensions and Horner steps in phase slots.
// Drives coefficient reads, multiply-accumulate issues and result capture. Depends on ptev_pkg.
`default_nettype none
module ptev_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [ptev_pkg::ORDER_W-1:0]  n_eff,
  input  logic [ptev_pkg::DIM_W-1:0]    dims_eff,
  output logic                          busy,
  output logic [ptev_pkg::ORDER_W-1:0]  step,
  output logic [ptev_pkg::DIM_W-1:0]    dim,
  output ptev_pkg::issue_t              issue,
  output ptev_pkg::emit_t               emit
);
  import ptev_pkg::*;

  localparam logic [1:0] PH_LAST = 2'd3;

  state_t     state;
  state_t     state_next;
  logic [1:0] ph;
  logic       last_dim;

  assign last_dim = (dim == dims_eff - DIM_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (go) state_next = ST_STEP;
      end
      ST_STEP: begin
        if (ph == PH_LAST && step == '0) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (ph == PH_LAST) state_next = last_dim ? ST_IDLE : ST_STEP;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ph    <= '0;
      step  <= '0;
      dim   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (go) begin
            ph   <= '0;
            step <= n_eff;
            dim  <= '0;
          end
        end
        ST_STEP: begin
          ph <= ph + 2'd1;
          if (ph == PH_LAST && step != '0) step <= step - ORDER_W'(1);
        end
        ST_DRAIN: begin
          ph <= ph + 2'd1;
          if (ph == PH_LAST) begin
            step <= n_eff;
            dim  <= dim + DIM_W'(1);
          end
        end
        default: ph <= '0;
      endcase
    end
  end

  always_comb begin
    busy         = (state != ST_IDLE);
    issue.valid  = 1'b0;
    issue.load   = (step == n_eff);
    issue.chain  = CH_POS;
    emit.valid   = 1'b0;
    emit.last    = last_dim;
    emit.dim     = dim;
    unique case (state)
      ST_STEP: begin
        unique case (ph)
          2'd1: begin
            issue.chain = CH_POS;
            issue.valid = 1'b1;
          end
          2'd2: begin
            issue.chain = CH_VEL;
            issue.valid = issue.load || step >= ORDER_W'(1);
          end
          2'd3: begin
            issue.chain = CH_ACC;
            issue.valid = issue.load || step >= ORDER_W'(2);
          end
          default: issue.valid = 1'b0;
        endcase
      end
      ST_DRAIN: begin
        emit.valid = (ph == PH_LAST);
      end
      default: emit.valid = 1'b0;
    endcase
    issue.weight = deriv_weight(step, issue.chain);
  end

endmodule
`default_nettype wire

// ===== rtl/polynomial_trajectory_evaluator_core.sv =====
// Polynomial trajectory evaluator: position, velocity and acceleration by Horner's rule.
// Each Horner step of an evaluate is a slot of the shared multiply-accumulate pipeline.
// Negative time gives its error result in the next cycle. Synchronous reset marks every
// coefficient unwritten (reads zero), order 5, dimensions 3.
`default_nettype none
module polynomial_trajectory_evaluator_core #(
  parameter int MAX_COEFFS = 6,
  parameter int MAX_DIMS   = 3
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   operation,
  input  logic [ptev_pkg::ORDER_W-1:0]           coeff_index,
  input  logic [ptev_pkg::DIM_W-1:0]             dim_index,
  input  logic signed [ptev_pkg::COEFF_W-1:0]    coeff_value,
  input  logic signed [ptev_pkg::TVAL_W-1:0]     time_value,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ptev_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ptev_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                   result_strobe,
  output logic [ptev_pkg::DIM_W-1:0]             out_dim,
  output logic signed [ptev_pkg::ACC_W-1:0]      position,
  output logic signed [ptev_pkg::ACC_W-1:0]      velocity,
  output logic signed [ptev_pkg::ACC_W-1:0]      acceleration,
  output logic                                   status,
  output logic                                   last
);
  import ptev_pkg::*;

  localparam int DEPTH = MAX_COEFFS * MAX_DIMS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ORDER_W-1:0]        order_in_use;
  logic [DIM_W-1:0]          dims_in_use;
  logic [ORDER_W-1:0]        n_eff;
  logic [DIM_W-1:0]          dims_eff;
  logic                      accept;
  logic                      is_eval;
  logic                      go;
  logic                      err;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [AW-1:0]             rd_addr;
  logic signed [COEFF_W-1:0] rd_data;
  logic [TIME_W-1:0]         t_hold;
  logic [ORDER_W-1:0]        step;
  logic [DIM_W-1:0]          dim;
  issue_t                    issue;
  emit_t                     emit;
  q48_t                      acc [NUM_CHAINS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_in_use <= ORDER_RESET;
      dims_in_use  <= DIMS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ORDER) begin
        order_in_use <= cfg_data[ORDER_W-1:0];
      end else if (cfg_index == CFG_DIMS) begin
        dims_in_use <= cfg_data[DIM_W-1:0];
      end
    end
  end

  always_comb begin
    n_eff = (int'(order_in_use) > MAX_COEFFS - 1) ? ORDER_W'(MAX_COEFFS - 1) : order_in_use;
    if (dims_in_use == '0) begin
      dims_eff = DIM_W'(1);
    end else if (int'(dims_in_use) > MAX_DIMS) begin
      dims_eff = DIM_W'(MAX_DIMS);
    end else begin
      dims_eff = dims_in_use;
    end
  end

  assign accept  = start && !busy;
  assign is_eval = (operation == OP_EVAL);
  assign go      = accept && is_eval && !time_value[TVAL_W-1];
  assign err     = accept && is_eval && time_value[TVAL_W-1];
  assign wr_en   = accept && !is_eval && int'(coeff_index) < MAX_COEFFS
                   && int'(dim_index) < MAX_DIMS;
  assign wr_addr = AW'(int'(coeff_index) * MAX_DIMS + int'(dim_index));
  assign rd_addr = AW'(int'(step) * MAX_DIMS + int'(dim));

  always_ff @(posedge clk) begin
    if (go) begin
      t_hold <= time_value[TIME_W-1:0];
    end
  end

  ptev_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(coeff_value),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  ptev_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .n_eff   (n_eff),
    .dims_eff(dims_eff),
    .busy    (busy),
    .step    (step),
    .dim     (dim),
    .issue   (issue),
    .emit    (emit)
  );

  ptev_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .issue(issue),
    .coeff(rd_data),
    .t_val(t_hold),
    .acc  (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit.valid || err;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_dim      <= emit.dim;
      position     <= acc[CH_POS];
      velocity     <= acc[CH_VEL];
      acceleration <= acc[CH_ACC];
      status       <= 1'b0;
      last         <= emit.last;
    end else if (err) begin
      out_dim      <= '0;
      position     <= '0;
      velocity     <= '0;
      acceleration <= '0;
      status       <= 1'b1;
      last         <= 1'b1;
    end
  end

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && status |-> last)
    else $error("error beat without last");

  a_err_when_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe && status |-> !busy)
    else $error("error beat during an evaluation");

  a_busy_from_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && operation == OP_EVAL && !time_value[TVAL_W-1]))
    else $error("busy rose without an accepted evaluate");

  a_ok_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !status |-> $past(busy))
    else $error("result beat outside an evaluation");

endmodule
`default_nettype wire

// ===== test/polynomial_trajectory_evaluator_core_tb.sv =====
// Self-checking testbench for polynomial_trajectory_evaluator_core: coefficient writes,
// register settings and evaluations with random gaps, checked against a fixed-point Horner
// predictor in a scoreboard. Depends on ptev_pkg and the core RTL only.
`timescale 1ns / 1ps
module polynomial_trajectory_evaluator_core_tb;
  import ptev_pkg::*;

  localparam int     MAX_ORDERS    = 6;
  localparam int     MAX_AXES      = 3;
  localparam int     ITEMS_PER_SET = 12;
  localparam int     SETTLE_CYCLES = 90;
  localparam int     IDLE_LIMIT    = 1000;
  localparam int     MAX_PRINTED   = 100;
  localparam logic   STATUS_OK       = 1'b0;
  localparam logic   STATUS_NEG_TIME = 1'b1;
  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  typedef struct {
    op_t                        op;
    logic [ORDER_W-1:0]         k;
    logic [DIM_W-1:0]           d;
    logic signed [COEFF_W-1:0]  c;
    logic signed [TVAL_W-1:0]   t;
  } traj_cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0]         dim;
    logic signed [ACC_W-1:0]  position;
    logic signed [ACC_W-1:0]  velocity;
    logic signed [ACC_W-1:0]  acceleration;
    logic                     status;
    logic                     last;
  } traj_sample_t;

  class traj_scoreboard;
    logic signed [COEFF_W-1:0] coeff_bank [MAX_ORDERS][MAX_AXES];
    logic [ORDER_W-1:0]        order_reg;
    logic [DIM_W-1:0]          dims_reg;
    traj_sample_t              expected_q[$];
    int                        errors;

    function new();
      foreach (coeff_bank[k, d]) coeff_bank[k][d] = '0;
      order_reg = ORDER_RESET;
      dims_reg  = DIMS_RESET;
      errors    = 0;
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("%0t ns: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ORDER: order_reg = ORDER_W'(data);
        CFG_DIMS:  dims_reg = DIM_W'(data);
        default: ;
      endcase
    endfunction

    function longint clamp48(longint v);
      if (v > ACC_MAX) return ACC_MAX;
      if (v < ACC_MIN) return ACC_MIN;
      return v;
    endfunction

    // Product of a Q32.16 value and a nonnegative Q7.16 time, magnitude rounded half away.
    function longint scale_by_time(longint acc, logic [TIME_W-1:0] t);
      longint unsigned mag;
      longint unsigned whole;
      longint unsigned frac;
      longint unsigned p;
      mag   = (acc < 0) ? -acc : acc;
      whole = 64'(t[TIME_W-1:FRAC_W]);
      frac  = 64'(t[FRAC_W-1:0]);
      p = mag * whole + ((mag * frac + 64'h8000) >> FRAC_W);
      return (acc < 0) ? -longint'(p) : longint'(p);
    endfunction

    function longint weighted(int k, int d, int deriv);
      longint c;
      longint w;
      c = longint'(coeff_bank[k][d]);
      w = (deriv == 0) ? 1 : (deriv == 1) ? k : k * (k - 1);
      return c * w;
    endfunction

    function longint horner(int d, int deriv, int n, logic [TIME_W-1:0] t);
      longint acc;
      int     k;
      if (n < deriv) return 0;
      acc = clamp48(weighted(n, d, deriv));
      for (k = n; k > deriv; k--)
        acc = clamp48(scale_by_time(acc, t) + weighted(k - 1, d, deriv));
      return acc;
    endfunction

    function void note_command(traj_cmd_t cmd);
      int                 n;
      int                 axes;
      traj_sample_t       s;
      logic [TIME_W-1:0]  t;
      if (cmd.op == OP_WRITE) begin
        if (cmd.k < MAX_ORDERS && cmd.d < MAX_AXES) coeff_bank[cmd.k][cmd.d] = cmd.c;
        return;
      end
      if (cmd.t < 0) begin
        s = '{dim: '0, position: '0, velocity: '0, acceleration: '0,
              status: STATUS_NEG_TIME, last: 1'b1};
        expected_q.insert(expected_q.size(), s);
        return;
      end
      n    = (order_reg > MAX_ORDERS - 1) ? MAX_ORDERS - 1 : order_reg;
      axes = (dims_reg == 0) ? 1 : (dims_reg > MAX_AXES) ? MAX_AXES : dims_reg;
      t    = cmd.t[TIME_W-1:0];
      for (int d = 0; d < axes; d++) begin
        s.dim          = DIM_W'(d);
        s.position     = ACC_W'(horner(d, 0, n, t));
        s.velocity     = ACC_W'(horner(d, 1, n, t));
        s.acceleration = ACC_W'(horner(d, 2, n, t));
        s.status       = STATUS_OK;
        s.last         = (d == axes - 1);
        expected_q.insert(expected_q.size(), s);
      end
    endfunction

    task check_result(traj_sample_t got);
      traj_sample_t want;
      string        bad;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result for dim %0d", got.dim));
        return;
      end
      want = expected_q.pop_front();
      bad  = "";
      if (got.dim !== want.dim) bad = {bad, " dim"};
      if (got.position !== want.position) bad = {bad, " position"};
      if (got.velocity !== want.velocity) bad = {bad, " velocity"};
      if (got.acceleration !== want.acceleration) bad = {bad, " acceleration"};
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.last !== want.last) bad = {bad, " last"};
      if (bad != "")
        report($sformatf("wrong%s: got %0d/%0d/%0d/%0d/%0b/%0b want %0d/%0d/%0d/%0d/%0b/%0b",
                         bad, got.dim, got.position, got.velocity, got.acceleration,
                         got.status, got.last, want.dim, want.position, want.velocity,
                         want.acceleration, want.status, want.last));
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic                         operation;
  logic [ORDER_W-1:0]           coeff_index;
  logic [DIM_W-1:0]             dim_index;
  logic signed [COEFF_W-1:0]    coeff_value;
  logic signed [TVAL_W-1:0]     time_value;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;
  logic                         result_strobe;
  logic [DIM_W-1:0]             out_dim;
  logic signed [ACC_W-1:0]      position;
  logic signed [ACC_W-1:0]      velocity;
  logic signed [ACC_W-1:0]      acceleration;
  logic                         status;
  logic                         last;

  traj_scoreboard sb;
  int             idle_cycles;

  polynomial_trajectory_evaluator_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .coeff_index(coeff_index), .dim_index(dim_index),
    .coeff_value(coeff_value), .time_value(time_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_strobe(result_strobe), .out_dim(out_dim), .position(position),
    .velocity(velocity), .acceleration(acceleration), .status(status), .last(last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_strobe)
      sb.check_result({out_dim, position, velocity, acceleration, status, last});
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("polynomial_trajectory_evaluator_core_tb: errors");
        $finish;
      end
    end
  end

  function automatic traj_cmd_t make_write(int k, int d, logic [COEFF_W-1:0] c);
    traj_cmd_t cmd;
    cmd.op = OP_WRITE;
    cmd.k  = ORDER_W'(k);
    cmd.d  = DIM_W'(d);
    cmd.c  = c;
    cmd.t  = TVAL_W'($urandom);
    return cmd;
  endfunction

  function automatic traj_cmd_t make_eval(logic [TVAL_W-1:0] t);
    traj_cmd_t cmd;
    cmd.op = OP_EVAL;
    cmd.k  = ORDER_W'($urandom);
    cmd.d  = DIM_W'($urandom);
    cmd.c  = COEFF_W'($urandom);
    cmd.t  = t;
    return cmd;
  endfunction

  function automatic traj_cmd_t random_command();
    int k;
    int d;
    int r;
    logic [COEFF_W-1:0] c;
    logic [TVAL_W-1:0]  t;
    if ($urandom_range(99) < 55) begin
      k = ($urandom_range(99) < 90) ? $urandom_range(MAX_ORDERS - 1) : $urandom_range(7);
      d = ($urandom_range(99) < 90) ? $urandom_range(MAX_AXES - 1) : $urandom_range(3);
      c = ($urandom_range(99) < 70) ? COEFF_W'(int'($urandom_range(1 << 19)) - (1 << 18))
                                    : COEFF_W'($urandom);
      return make_write(k, d, c);
    end
    r = $urandom_range(99);
    if (r < 10)      t = TVAL_W'(-int'($urandom_range(8388608, 1)));
    else if (r < 60) t = TVAL_W'($urandom_range(24'h030000));
    else if (r < 85) t = TVAL_W'($urandom_range(24'h100000));
    else             t = TVAL_W'($urandom_range(24'h7FFFFF));
    return make_eval(t);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_command(traj_cmd_t cmd, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    operation   <= cmd.op;
    coeff_index <= cmd.k;
    dim_index   <= cmd.d;
    coeff_value <= cmd.c;
    time_value  <= cmd.t;
    do @(posedge clk); while (busy);
    sb.note_command(cmd);
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers go out as two back-to-back beats on the configuration channel.
  task automatic apply_settings(logic [CFG_DATA_W-1:0] order, logic [CFG_DATA_W-1:0] dims);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ORDER;
    cfg_data  <= order;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(CFG_ORDER, order);
    cfg_index <= CFG_DIMS;
    cfg_data  <= dims;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(CFG_DIMS, dims);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    traj_cmd_t directed[$];
    int        order_plan [9];
    int        dims_plan [9];
    bit        steady;

    order_plan  = '{0, 1, 2, 7, 6, 3, 4, 5, 5};
    dims_plan   = '{1, 2, 3, 3, 0, 2, 1, 3, 2};
    sb          = new();
    idle_cycles = 0;
    rst         = 1'b1;
    start       = 1'b0;
    operation   = OP_WRITE;
    coeff_index = '0;
    dim_index   = '0;
    coeff_value = '0;
    time_value  = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_ORDER;
    cfg_data    = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    directed.insert(directed.size(), make_eval(24'h010000));
    directed.insert(directed.size(), make_write(0, 0, 32'h0001_0000));
    directed.insert(directed.size(), make_write(1, 0, 32'h0002_0000));
    directed.insert(directed.size(), make_write(5, 0, 32'h7FFF_FFFF));
    directed.insert(directed.size(), make_write(0, 1, 32'h8000_0000));
    directed.insert(directed.size(), make_write(2, 2, -32'sh0003_0000));
    directed.insert(directed.size(), make_write(5, 2, 32'h1234_5678));
    directed.insert(directed.size(), make_write(4, 1, 32'hFFFF_8000));
    directed.insert(directed.size(), make_write(6, 0, 32'h5555_5555));
    directed.insert(directed.size(), make_write(7, 3, 32'hFFFF_FFFF));
    directed.insert(directed.size(), make_write(3, 3, 32'hAAAA_AAAA));
    directed.insert(directed.size(), make_eval(24'h000000));
    directed.insert(directed.size(), make_eval(24'h010000));
    directed.insert(directed.size(), make_eval(24'h7FFFFF));
    directed.insert(directed.size(), make_eval(24'hFFFFFF));
    directed.insert(directed.size(), make_eval(24'h800000));
    directed.insert(directed.size(), make_eval(24'h008000));
    directed.insert(directed.size(), make_eval(24'h000001));
    directed.insert(directed.size(), make_write(5, 0, 32'h0000_0000));
    directed.insert(directed.size(), make_eval(24'h018000));
    foreach (directed[i]) send_command(directed[i], (i % 4 == 3) ? pick_gap() : 0);

    foreach (order_plan[p]) begin
      quiesce();
      apply_settings(CFG_DATA_W'(order_plan[p]), CFG_DATA_W'(dims_plan[p]));
      steady = (p % 3 == 1);
      for (int i = 0; i < ITEMS_PER_SET; i++)
        send_command(random_command(), steady ? 0 : pick_gap());
    end
    quiesce();

    foreach (sb.expected_q[i])
      sb.report($sformatf("missing result for dim %0d", sb.expected_q[i].dim));
    if (sb.errors == 0) begin
      $display("polynomial_trajectory_evaluator_core_tb: clean");
    end else begin
      $display("polynomial_trajectory_evaluator_core_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ptev_pkg.sv
rtl/ptev_store.sv
rtl/ptev_mac.sv
rtl/ptev_ctrl.sv
rtl/polynomial_trajectory_evaluator_core.sv
test/polynomial_trajectory_evaluator_core_tb.sv
